FILE: hw/rtl/ims_pkg.sv
// ---------------------------------------------------------------------------
// ims_pkg: shared types and constants of the Ising spin update engine
// Holds field widths, command and register codes, the controller state
// encoding and the struct types passed between the engine's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

   // Request and response field widths.
   localparam int COORD_W    = 6;
   localparam int COORD_EXT  = 9;    // coordinate widened so it can hold 256
   localparam int THR_W      = 7;
   localparam int THR_COUNT  = 9;
   localparam int TABLE_W    = THR_W * THR_COUNT;
   localparam int RSP_SUM_W  = 14;
   localparam int NSUM_W     = 4;
   localparam int BOND_D_W   = 5;
   localparam int SPIN_D_W   = 3;

   // Bias that turns a neighbour sum of -4..4 into a table slot of 0..8.
   localparam logic [NSUM_W-1:0] NSUM_BIAS = 4'd4;

   // Request commands.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TRIAL = 1'b1;

   // Register indexes on the write port.
   localparam logic CSR_TABLE_UP   = 1'b0;
   localparam logic CSR_TABLE_DOWN = 1'b1;

   // Neighbour slots.
   localparam int NBR_RIGHT = 0;
   localparam int NBR_LEFT  = 1;
   localparam int NBR_DOWN  = 2;
   localparam int NBR_UP    = 3;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EVAL  = 3'b100
   } ctl_state_type;

   // The four neighbours of a site: whether each lies inside the lattice
   // and its spin (1 is +1, 0 is -1).
   typedef struct packed {
      logic [3:0] present;
      logic [3:0] spin;
   } nbr_type;

   // Outcome of one request at a site.
   typedef struct packed {
      logic                       flip;        // the site changes its spin
      logic                       flipped;     // reported flag, trials only
      logic                       spin_new;
      logic signed [BOND_D_W-1:0] bond_delta;
      logic signed [SPIN_D_W-1:0] spin_delta;
   } eval_result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ims_row_store.sv
// ---------------------------------------------------------------------------
// ims_row_store: spin lattice memory, one row per word
// Synchronous memory with two read ports and one write port. A row that
// was never written since reset reads as all spins +1 by way of one valid
// bit per row.
// ---------------------------------------------------------------------------
`default_nettype none

module ims_row_store
   import ims_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(SIDE)-1:0]    rd_a_addr,
   input  wire logic [$clog2(SIDE)-1:0]    rd_b_addr,
   output      logic [SIDE-1:0]            rd_a_row,
   output      logic [SIDE-1:0]            rd_b_row,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(SIDE)-1:0]    wr_addr,
   input  wire logic [SIDE-1:0]            wr_row
);

   logic [SIDE-1:0] mem [SIDE];
   logic [SIDE-1:0] row_valid_ff;
   logic [SIDE-1:0] rd_a_ff;
   logic [SIDE-1:0] rd_b_ff;
   logic            a_valid_ff;
   logic            b_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         a_valid_ff <= row_valid_ff[rd_a_addr];
         b_valid_ff <= row_valid_ff[rd_b_addr];
      end
   end

   assign rd_a_row = a_valid_ff ? rd_a_ff : '1;
   assign rd_b_row = b_valid_ff ? rd_b_ff : '1;

endmodule

`default_nettype wire

FILE: hw/rtl/ims_trial_eval.sv
// ---------------------------------------------------------------------------
// ims_trial_eval: neighbour sum, acceptance test and total deltas
// Decides whether a load or a Metropolis trial changes the site and how
// the bond sum and magnetization move when it does.
// ---------------------------------------------------------------------------
`default_nettype none

module ims_trial_eval
   import ims_pkg::*;
(
   input  wire logic               action,
   input  wire logic               cur_spin,
   input  wire logic               load_value,
   input  wire logic [THR_W-1:0]   rand_percent,
   input  wire nbr_type            nbr,
   input  wire logic [TABLE_W-1:0] table_up,
   input  wire logic [TABLE_W-1:0] table_down,
   output      eval_result_type    res
);

   logic signed [NSUM_W-1:0]   nsum;
   logic [NSUM_W-1:0]          slot;
   logic [TABLE_W-1:0]         table_sel;
   logic [TABLE_W-1:0]         shifted;
   logic [THR_W-1:0]           thr;
   logic signed [BOND_D_W-1:0] two_nsum;
   logic                       flip;

   always_comb begin
      nsum = '0;
      for (int i = 0; i < 4; i++) begin
         if (nbr.present[i]) begin
            nsum = nbr.spin[i] ? nsum + 4'sd1 : nsum - 4'sd1;
         end
      end
   end

   assign slot      = $unsigned(nsum) + NSUM_BIAS;
   assign table_sel = cur_spin ? table_up : table_down;
   assign shifted   = table_sel >> (THR_W * slot);
   assign thr       = shifted[THR_W-1:0];
   assign two_nsum  = {nsum[NSUM_W-1], nsum} <<< 1;

   always_comb begin
      unique case (action)
         ACT_LOAD:  flip = (cur_spin != load_value);
         ACT_TRIAL: flip = (rand_percent < thr);
         default:   flip = 1'b0;
      endcase
   end

   always_comb begin
      res.flip     = flip;
      res.flipped  = flip && (action == ACT_TRIAL);
      res.spin_new = flip ? ~cur_spin : cur_spin;
      // A flip of spin s with neighbour sum n moves the bond sum by -2*s*n
      // and the magnetization by -2*s.
      if (!flip) begin
         res.bond_delta = '0;
         res.spin_delta = '0;
      end else if (cur_spin) begin
         res.bond_delta = -two_nsum;
         res.spin_delta = -3'sd2;
      end else begin
         res.bond_delta = two_nsum;
         res.spin_delta = 3'sd2;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ising_metropolis_spin_update.sv
// ---------------------------------------------------------------------------
// ising_metropolis_spin_update: Metropolis spin update for a 2D Ising lattice
// Keeps a square lattice of +1/-1 spins with open boundaries and serves
// load and Metropolis trial requests one site at a time.
// ---------------------------------------------------------------------------
// Usage. A request on the req_ channel either loads one spin (req_action is
// load) or makes one Metropolis trial at (req_row, req_col): the spin flips
// when req_rand_percent is below the threshold that software placed in the
// up or down table at slot neighbour sum plus four. Each request gives
// exactly one response on the rsp_ channel with the flip flag, the spin now
// at the site, and the running bond sum and magnetization after the request.
// Steps. The accept cycle issues the reads of the site row and the row
// above, the fetch step reads the row below, and the eval step decides,
// writes the row back and loads the response register. The block takes a
// new request only once the last one has committed, as req_ready is high
// only while idle.
// Reset sets the totals to their all-up values and clears the tables; every
// spin reads as +1 after reset, so no clearing pass is needed.
// When the receiver stalls, the response register holds; the block still
// takes the next request and waits in its last step until the register is
// free. The user must write the tables through the csr_ port only while no
// request is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update
   import ims_pkg::*;
#(
   parameter int LATTICE_SIDE = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic                        req_action,
   input  wire logic [COORD_W-1:0]          req_row,
   input  wire logic [COORD_W-1:0]          req_col,
   input  wire logic                        req_load_value,
   input  wire logic [THR_W-1:0]            req_rand_percent,
   // response channel
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_flipped,
   output      logic                        rsp_spin_now,
   output      logic signed [RSP_SUM_W-1:0] rsp_bond_sum,
   output      logic signed [RSP_SUM_W-1:0] rsp_magnetization,
   // register write port
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [TABLE_W-1:0]          csr_wr_data
);

   localparam int AW     = $clog2(LATTICE_SIDE);
   localparam int TW_RAW = $clog2(2 * LATTICE_SIDE * LATTICE_SIDE + 1) + 1;
   localparam int TW     = (TW_RAW > RSP_SUM_W) ? TW_RAW : RSP_SUM_W;
   localparam logic [COORD_EXT-1:0] SIDE_EXT = COORD_EXT'(LATTICE_SIDE);
   localparam logic signed [TW-1:0] BOND_RESET =
      TW'(2 * LATTICE_SIDE * (LATTICE_SIDE - 1));
   localparam logic signed [TW-1:0] SPIN_RESET = TW'(LATTICE_SIDE * LATTICE_SIDE);

   // Control and request registers.
   ctl_state_type       state_ff, state_in;
   logic                act_ff;
   logic                load_ff;
   logic [THR_W-1:0]    rand_ff;
   logic [COORD_EXT-1:0] row_ext_ff;
   logic [COORD_EXT-1:0] col_ext_ff;
   logic                in_range_ff;

   // Row data captured in the fetch step.
   logic [LATTICE_SIDE-1:0] center_row_ff;
   logic                    up_spin_ff;

   // Running totals and tables.
   logic signed [TW-1:0] bond_ff;
   logic signed [TW-1:0] mag_ff;
   logic signed [TW-1:0] bond_in;
   logic signed [TW-1:0] mag_in;
   logic [TABLE_W-1:0]   table_up_ff;
   logic [TABLE_W-1:0]   table_down_ff;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_flipped_ff;
   logic                        rsp_spin_now_ff;
   logic signed [RSP_SUM_W-1:0] rsp_bond_ff;
   logic signed [RSP_SUM_W-1:0] rsp_mag_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 commit;
   logic [COORD_EXT-1:0] req_row_ext;
   logic [COORD_EXT-1:0] req_col_ext;
   logic [COORD_EXT-1:0] req_row_dec;
   logic [COORD_EXT-1:0] row_inc;
   logic [COORD_EXT-1:0] col_inc;
   logic [AW-1:0]        row_idx;
   logic [AW-1:0]        col_idx;
   logic [AW-1:0]        col_idx_p1;
   logic [AW-1:0]        col_idx_m1;
   logic [AW-1:0]        rd_a_addr;
   logic [AW-1:0]        rd_b_addr;
   logic [LATTICE_SIDE-1:0] rd_a_row;
   logic [LATTICE_SIDE-1:0] rd_b_row;
   logic [LATTICE_SIDE-1:0] row_new;
   logic                 mem_wr_en;
   nbr_type              nbr;
   eval_result_type      res;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign commit      = (state_ff == ST_EVAL) && out_free;

   assign req_row_ext = {{(COORD_EXT - COORD_W){1'b0}}, req_row};
   assign req_col_ext = {{(COORD_EXT - COORD_W){1'b0}}, req_col};
   assign req_row_dec = req_row_ext - COORD_EXT'(1);
   assign row_inc     = row_ext_ff + COORD_EXT'(1);
   assign col_inc     = col_ext_ff + COORD_EXT'(1);
   assign row_idx     = row_ext_ff[AW-1:0];
   assign col_idx     = col_ext_ff[AW-1:0];
   assign col_idx_p1  = col_idx + AW'(1);
   assign col_idx_m1  = col_idx - AW'(1);

   // The accept cycle reads the site row on port A and the row above on
   // port B; afterwards port A reads the row below and holds that address
   // while the last step waits for the response register.
   assign rd_a_addr = (state_ff == ST_IDLE) ? req_row_ext[AW-1:0] : row_inc[AW-1:0];
   assign rd_b_addr = req_row_dec[AW-1:0];

   ims_row_store #(
      .SIDE (LATTICE_SIDE)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_row  (rd_a_row),
      .rd_b_row  (rd_b_row),
      .wr_en     (mem_wr_en),
      .wr_addr   (row_idx),
      .wr_row    (row_new)
   );

   // Neighbours outside the lattice are masked off by their present bits.
   always_comb begin
      nbr.present[NBR_RIGHT] = (col_inc < SIDE_EXT);
      nbr.present[NBR_LEFT]  = (col_ext_ff != '0);
      nbr.present[NBR_DOWN]  = (row_inc < SIDE_EXT);
      nbr.present[NBR_UP]    = (row_ext_ff != '0);
      nbr.spin[NBR_RIGHT]    = nbr.present[NBR_RIGHT] ? center_row_ff[col_idx_p1] : 1'b0;
      nbr.spin[NBR_LEFT]     = nbr.present[NBR_LEFT] ? center_row_ff[col_idx_m1] : 1'b0;
      nbr.spin[NBR_DOWN]     = nbr.present[NBR_DOWN] ? rd_a_row[col_idx] : 1'b0;
      nbr.spin[NBR_UP]       = up_spin_ff;
   end

   ims_trial_eval u_eval (
      .action       (act_ff),
      .cur_spin     (center_row_ff[col_idx]),
      .load_value   (load_ff),
      .rand_percent (rand_ff),
      .nbr          (nbr),
      .table_up     (table_up_ff),
      .table_down   (table_down_ff),
      .res          (res)
   );

   always_comb begin
      row_new          = center_row_ff;
      row_new[col_idx] = res.spin_new;
   end

   // A site outside the lattice changes nothing.
   assign mem_wr_en = commit && in_range_ff && res.flip;
   assign bond_in   = (in_range_ff && res.flip) ? bond_ff + TW'(res.bond_delta) : bond_ff;
   assign mag_in    = (in_range_ff && res.flip) ? mag_ff + TW'(res.spin_delta) : mag_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EVAL;
         ST_EVAL:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bond_ff       <= BOND_RESET;
         mag_ff        <= SPIN_RESET;
         table_up_ff   <= '0;
         table_down_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TABLE_UP:   table_up_ff   <= csr_wr_data;
               CSR_TABLE_DOWN: table_down_ff <= csr_wr_data;
               default:        table_up_ff   <= table_up_ff;
            endcase
         end
         if (commit) begin
            bond_ff      <= bond_in;
            mag_ff       <= mag_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff      <= req_action;
         load_ff     <= req_load_value;
         rand_ff     <= req_rand_percent;
         row_ext_ff  <= req_row_ext;
         col_ext_ff  <= req_col_ext;
         in_range_ff <= (req_row_ext < SIDE_EXT) && (req_col_ext < SIDE_EXT);
      end
      if (state_ff == ST_FETCH) begin
         center_row_ff <= rd_a_row;
         up_spin_ff    <= (row_ext_ff != '0) ? rd_b_row[col_idx] : 1'b0;
      end
      if (commit) begin
         rsp_flipped_ff  <= in_range_ff && res.flipped;
         rsp_spin_now_ff <= in_range_ff && res.spin_new;
         rsp_bond_ff     <= bond_in[RSP_SUM_W-1:0];
         rsp_mag_ff      <= mag_in[RSP_SUM_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flipped       = rsp_flipped_ff;
   assign rsp_spin_now      = rsp_spin_now_ff;
   assign rsp_bond_sum      = rsp_bond_ff;
   assign rsp_magnetization = rsp_mag_ff;

   // The lattice is written only in the last step, once the response
   // register can take the result.
   a_write_in_commit : assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_EVAL) && out_free)
      else $error("row store written outside the commit step");

   // Magnetization moves by at most one spin flip per cycle.
   a_mag_step : assert property (@(posedge clock) disable iff (reset)
      !reset |=> (mag_ff == $past(mag_ff)) || (mag_ff == $past(mag_ff) + TW'(2))
                 || (mag_ff == $past(mag_ff) - TW'(2)))
      else $error("magnetization changed by more than one flip");

   // A commit always leaves a response waiting.
   a_commit_rsp : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed request without response");

   // Totals change only together with a committed request.
   a_totals_commit : assert property (@(posedge clock) disable iff (reset)
      !commit |=> (bond_ff == $past(bond_ff)) && (mag_ff == $past(mag_ff)))
      else $error("totals changed without a commit");

endmodule

`default_nettype wire
